/* rtl/mse_pkg.sv */
`timescale 1ns / 1ps

package mse_pkg;

  // Width of one stored value and of the padded stream data word.
  localparam int unsigned ValueWidth   = 31;
  localparam int unsigned TdataWidth   = 32;

  // Default number of buffer entries.
  localparam int unsigned DefaultDepth = 64;

endpackage

/* rtl/mse_ram.sv */
`timescale 1ns / 1ps

module mse_ram #(
  parameter int unsigned Depth = mse_pkg::DefaultDepth,
  parameter int unsigned Width = mse_pkg::ValueWidth,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/merge_sort_engine_core.sv */
`timescale 1ns / 1ps
// Loading takes one word per cycle; the block is ready only while loading.
// Sorting runs ceil(log2 n) merge passes, each element read (StMrgRead) and written (StMrgWr)
// through one compare unit and the two-read buffer memory; output then reads (StOutRead) and
// sends (StOutWr) each word, and StOutWr waits while a held result word is not taken.
// Reset (rst_ni low, asynchronous) clears the sequencer, load count and flags; pointers and buffers are not cleared.

module merge_sort_engine_core #(
  parameter int unsigned DEPTH = mse_pkg::DefaultDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // Bits from lowest: value[30:0], zero pad [31].
  input  logic [mse_pkg::TdataWidth-1:0] s_axis_tdata_i,
  // final_item.
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // Bits from lowest: sorted_value[30:0], zero pad [31].
  output logic [mse_pkg::TdataWidth-1:0] m_axis_tdata_o,
  // end_of_run.
  output logic                           m_axis_tlast_o,
  // overflowed.
  output logic                           m_axis_tuser_o
);

  localparam int unsigned VW = mse_pkg::ValueWidth;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = CW + 1;

  localparam logic [2:0] StLoad    = 3'd0;
  localparam logic [2:0] StMrgRead = 3'd1;
  localparam logic [2:0] StMrgWr   = 3'd2;
  localparam logic [2:0] StOutRead = 3'd3;
  localparam logic [2:0] StOutWr   = 3'd4;

  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] width_q, width_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, mid_q, mid_d, hi_q, hi_d;
  logic          side_q, side_d;

  logic          out_vld_q, out_vld_d;
  logic [VW-1:0] out_data_q, out_data_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  logic          s_acc;
  logic [CW-1:0] cnt_inc;
  logic          take_left;
  logic [VW-1:0] rd_a, rd_b, mrg_data;
  logic [PW-1:0] mid_sum, hi_sum, w2;
  logic [PW:0]   hi_p_sum;
  logic [CW-1:0] mid_nx, hi_nx, mid_p, hi_p;

  logic          we0, we1;
  logic [AW-1:0] wa0, wa1, ra_a, ra_b;
  logic [VW-1:0] wd0;
  logic [VW-1:0] r0a, r0b, r1a, r1b;

  assign s_axis_tready_o = (state_q == StLoad);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_inc         = cnt_q + OneC;

  // Source buffer read data and the shared compare.
  assign rd_a      = side_q ? r1a : r0a;
  assign rd_b      = side_q ? r1b : r0b;
  assign take_left = (i_q < mid_q) && ((j_q >= hi_q) || (rd_a <= rd_b));
  assign mrg_data  = take_left ? rd_a : rd_b;

  // Bounds of the next run pair within this pass.
  assign mid_sum = {1'b0, hi_q} + {1'b0, width_q};
  assign hi_sum  = {1'b0, hi_q} + {width_q, 1'b0};
  assign mid_nx  = (mid_sum >= {1'b0, n_q}) ? n_q : mid_sum[CW-1:0];
  assign hi_nx   = (hi_sum >= {1'b0, n_q}) ? n_q : hi_sum[CW-1:0];

  // Bounds of the first run pair of the next pass.
  assign w2       = {width_q, 1'b0};
  assign hi_p_sum = {w2, 1'b0};
  assign mid_p    = (w2 >= {1'b0, n_q}) ? n_q : w2[CW-1:0];
  assign hi_p     = (hi_p_sum >= {2'b00, n_q}) ? n_q : hi_p_sum[CW-1:0];

  // Memory port steering: buffer 0 takes loads and merges into it.
  // The output address is held while a word waits, so a stall rereads it.
  always_comb begin
    ra_a = i_q[AW-1:0];
    ra_b = j_q[AW-1:0];
    if ((state_q == StOutRead) || (state_q == StOutWr)) begin
      ra_a = k_q[AW-1:0];
    end
    we0 = 1'b0;
    wa0 = k_q[AW-1:0];
    wd0 = mrg_data;
    if (s_acc && (cnt_q < DepthC)) begin
      we0 = 1'b1;
      wa0 = cnt_q[AW-1:0];
      wd0 = s_axis_tdata_i[VW-1:0];
    end else if ((state_q == StMrgWr) && side_q) begin
      we0 = 1'b1;
    end
    we1 = (state_q == StMrgWr) && !side_q;
    wa1 = k_q[AW-1:0];
  end

  mse_ram #(
    .Depth (DEPTH),
    .Width (VW)
  ) u_buf0 (
    .clk_i     (clk_i),
    .we_i      (we0),
    .waddr_i   (wa0),
    .wdata_i   (wd0),
    .raddr_a_i (ra_a),
    .raddr_b_i (ra_b),
    .rdata_a_o (r0a),
    .rdata_b_o (r0b)
  );

  mse_ram #(
    .Depth (DEPTH),
    .Width (VW)
  ) u_buf1 (
    .clk_i     (clk_i),
    .we_i      (we1),
    .waddr_i   (wa1),
    .wdata_i   (mrg_data),
    .raddr_a_i (ra_a),
    .raddr_b_i (ra_b),
    .rdata_a_o (r1a),
    .rdata_b_o (r1b)
  );

  // Sequencer: load, merge passes (skipped for a single word), then output.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    n_d        = n_q;
    width_d    = width_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    mid_d      = mid_q;
    hi_d       = hi_q;
    side_d     = side_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StLoad: begin
        if (s_acc) begin
          if (cnt_q < DepthC) begin
            cnt_d = cnt_inc;
            n_d   = cnt_inc;
          end else begin
            drop_d = 1'b1;
            n_d    = cnt_q;
          end
          if (s_axis_tlast_i) begin
            side_d  = 1'b0;
            k_d     = '0;
            width_d = OneC;
            i_d     = '0;
            mid_d   = OneC;
            j_d     = OneC;
            hi_d    = CW'(2);
            // A single word needs no merging.
            if ((cnt_q == '0) && (DEPTH > 0)) begin
              state_d = StOutRead;
            end else begin
              state_d = StMrgRead;
            end
          end
        end
      end
      StMrgRead: begin
        state_d = StMrgWr;
      end
      StMrgWr: begin
        k_d     = k_q + OneC;
        state_d = StMrgRead;
        if (take_left) begin
          i_d = i_q + OneC;
        end else begin
          j_d = j_q + OneC;
        end
        if ((k_q + OneC) == hi_q) begin
          if (hi_q == n_q) begin
            // Pass done: swap buffers, then output if the runs cover all words, else double the run width.
            side_d = !side_q;
            k_d    = '0;
            if (w2 >= {1'b0, n_q}) begin
              state_d = StOutRead;
            end else begin
              width_d = w2[CW-1:0];
              i_d     = '0;
              mid_d   = mid_p;
              j_d     = mid_p;
              hi_d    = hi_p;
            end
          end else begin
            i_d   = hi_q;
            mid_d = mid_nx;
            j_d   = mid_nx;
            hi_d  = hi_nx;
          end
        end
      end
      StOutRead: begin
        state_d = StOutWr;
      end
      StOutWr: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_data_d = rd_a;
          out_last_d = ((k_q + OneC) == n_q);
          out_ovf_d  = drop_q;
          k_d        = k_q + OneC;
          if ((k_q + OneC) == n_q) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = StLoad;
          end else begin
            state_d = StOutRead;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Working pointers and output word.
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    width_q    <= width_d;
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    mid_q      <= mid_d;
    hi_q       <= hi_d;
    side_q     <= side_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(mse_pkg::TdataWidth - VW){1'b0}}, out_data_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

endmodule
